@@ rtl/rffd_pkg.sv @@
// Package with the shared types and command codes of the fan remote frame decoder.
`timescale 1ns / 1ps

package rffd_pkg;

  // Table geometry.
  localparam int FAN_COUNT = 16;
  localparam int FAN_ID_W  = $clog2(FAN_COUNT);

  // Frame acceptance limits.
  localparam logic [4:0]  PROT_MIN   = 5'd11;
  localparam logic [4:0]  PROT_MAX   = 5'd13;
  localparam logic [5:0]  FRAME_BITS = 6'd12;
  localparam logic [15:0] WINDOW_RST = 16'd500;

  // Command codes carried in code bits 5..0.
  localparam logic [5:0] CMD_DIR_TOGGLE   = 6'h3b;
  localparam logic [5:0] CMD_LIGHT_TOGGLE = 6'h3e;
  localparam logic [5:0] CMD_SPEED_1      = 6'h37;
  localparam logic [5:0] CMD_SPEED_2      = 6'h35;
  localparam logic [5:0] CMD_SPEED_3      = 6'h2f;
  localparam logic [5:0] CMD_SPEED_4      = 6'h27;
  localparam logic [5:0] CMD_SPEED_5      = 6'h1d;
  localparam logic [5:0] CMD_SPEED_6      = 6'h1f;
  localparam logic [5:0] CMD_FAN_OFF      = 6'h3d;

  // One entry of the fan table.
  typedef struct packed {
    logic       fade_on;
    logic       direction_up;
    logic       light_on;
    logic       fan_on;
    logic [2:0] speed;
  } fan_entry_t;

  localparam int ENTRY_W = $bits(fan_entry_t);

  // Decoded request handed from the front end to the update stage.
  typedef struct packed {
    logic [FAN_ID_W-1:0] id;
    logic                fade_on;
    logic [5:0]          cmd;
  } fan_req_t;

endpackage

@@ rtl/rffd_if.sv @@
// Handshake interfaces for the frame input channel and the fan state result channel.
`timescale 1ns / 1ps

interface rffd_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] rf_code;
  logic [4:0]  protocol;
  logic [5:0]  bit_count;
  logic [31:0] time_ms;

  modport source (output valid, rf_code, protocol, bit_count, time_ms, input ready);
  modport sink   (input valid, rf_code, protocol, bit_count, time_ms, output ready);
endinterface

interface rffd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] fan_id;
  logic       fade_on;
  logic       direction_up;
  logic       light_on;
  logic       fan_on;
  logic [2:0] speed;

  modport source (output valid, fan_id, fade_on, direction_up, light_on, fan_on, speed,
                  input ready);
  modport sink   (input valid, fan_id, fade_on, direction_up, light_on, fan_on, speed,
                  output ready);
endinterface

@@ rtl/rffd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module rffd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is requested.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/rffd_front.sv @@
// Frame filter, repeat suppression and request decode.
`timescale 1ns / 1ps

module rffd_front import rffd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [11:0] rf_code,
  input  logic [4:0]  protocol,
  input  logic [5:0]  bit_count,
  input  logic [31:0] time_ms,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        issue,
  output fan_req_t    req
);

  logic [15:0] window_r;
  logic [11:0] last_code_r;
  logic [31:0] last_time_r;
  logic [31:0] elapsed;
  logic        frame_ok;
  logic        repeat_hit;

  // A frame must carry the right protocol, length and a clear top bit.
  assign frame_ok = (protocol >= PROT_MIN) && (protocol <= PROT_MAX) &&
                    (bit_count == FRAME_BITS) && !rf_code[11];

  // Elapsed time wraps with the timestamp.
  assign elapsed    = time_ms - last_time_r;
  assign repeat_hit = (rf_code == last_code_r) && (elapsed < {16'd0, window_r});
  assign issue      = accept && frame_ok && !repeat_hit;

  // Decode the fan index, fade flag and command.
  assign req.id      = ~rf_code[10:7];
  assign req.fade_on = ~rf_code[6];
  assign req.cmd     = rf_code[5:0];

  // Repeat window register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
    end else if (cfg_we) begin
      window_r <= cfg_wdata;
    end
  end

  // Remember the last frame that produced a request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_code_r <= 12'd0;
      last_time_r <= 32'd0;
    end else if (issue) begin
      last_code_r <= rf_code;
      last_time_r <= time_ms;
    end
  end

endmodule

@@ rtl/rffd_update.sv @@
// Read-modify-write stage of the fan table and the result register.
`timescale 1ns / 1ps

module rffd_update import rffd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                issue,
  input  fan_req_t            req,
  output logic                take,
  input  fan_entry_t          rd_entry,
  output logic                wr_en,
  output logic [FAN_ID_W-1:0] wr_addr,
  output fan_entry_t          wr_entry,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FAN_ID_W-1:0] out_id,
  output fan_entry_t          out_entry
);

  logic                s1_valid_r;
  fan_req_t            s1_req_r;
  logic                s1_written_r;
  logic [FAN_COUNT-1:0] written_r;
  logic                fwd_valid_r;
  logic [FAN_ID_W-1:0] fwd_id_r;
  fan_entry_t          fwd_entry_r;
  logic                out_valid_r;
  logic [FAN_ID_W-1:0] out_id_r;
  fan_entry_t          out_entry_r;
  logic                s1_go;
  fan_entry_t          cur;
  fan_entry_t          upd;

  // The held request moves on when the result register is free or drains.
  assign s1_go = s1_valid_r && (!out_valid_r || out_ready);
  assign take  = !s1_valid_r || s1_go;

  // Pick the newest copy of the entry: the write of the previous request,
  // then the memory, then the reset value for an entry never written.
  always_comb begin
    if (fwd_valid_r && (fwd_id_r == s1_req_r.id)) begin
      cur = fwd_entry_r;
    end else if (s1_written_r) begin
      cur = rd_entry;
    end else begin
      cur = '0;
    end
  end

  // Apply the command.
  always_comb begin
    upd         = cur;
    upd.fade_on = s1_req_r.fade_on;
    case (s1_req_r.cmd)
      CMD_DIR_TOGGLE:   upd.direction_up = ~cur.direction_up;
      CMD_LIGHT_TOGGLE: upd.light_on     = ~cur.light_on;
      CMD_SPEED_1: begin upd.fan_on = 1'b1; upd.speed = 3'd0; end
      CMD_SPEED_2: begin upd.fan_on = 1'b1; upd.speed = 3'd1; end
      CMD_SPEED_3: begin upd.fan_on = 1'b1; upd.speed = 3'd2; end
      CMD_SPEED_4: begin upd.fan_on = 1'b1; upd.speed = 3'd3; end
      CMD_SPEED_5: begin upd.fan_on = 1'b1; upd.speed = 3'd4; end
      CMD_SPEED_6: begin upd.fan_on = 1'b1; upd.speed = 3'd5; end
      CMD_FAN_OFF:      upd.fan_on       = 1'b0;
      default:          upd.fan_on       = cur.fan_on;
    endcase
  end

  assign wr_en    = s1_go;
  assign wr_addr  = s1_req_r.id;
  assign wr_entry = upd;

  // Request holding stage, aligned with the memory read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take) begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (take && issue) begin
      s1_req_r     <= req;
      s1_written_r <= written_r[req.id];
    end
  end

  // Per-entry written flags stand in for clearing the table at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (s1_go) begin
      written_r[s1_req_r.id] <= 1'b1;
    end
  end

  // Copy of the latest write, which the memory read may have missed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (s1_go) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      fwd_id_r    <= s1_req_r.id;
      fwd_entry_r <= upd;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_id_r    <= s1_req_r.id;
      out_entry_r <= upd;
    end
  end

  assign out_valid = out_valid_r;
  assign out_id    = out_id_r;
  assign out_entry = out_entry_r;

endmodule

@@ rtl/rf_fan_remote_frame_decoder.sv @@
// Top level of the fan remote frame decoder.
`timescale 1ns / 1ps

// Decodes received remote frames into per-fan state. A frame is taken on
// every cycle in which the input request is valid and ready; ready stays
// high while the result register can drain, so one frame per cycle is
// sustained. Frames with the wrong protocol, bit count or top bit, and
// repeats of the last code inside the repeat window, give no result. Each
// other frame passes through the request holding stage, which is aligned
// with the registered read of the 16-entry fan table, whose single read
// port and forwarded last write set the rate, and then through the result
// register. The table reads as cleared after reset without a clearing
// pass. The repeat window register may be written only while the block
// is idle.
module rf_fan_remote_frame_decoder import rffd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rffd_in_if.sink     in_ch,
  rffd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic                take;
  logic                issue;
  fan_req_t            req;
  fan_entry_t          rd_entry;
  logic [ENTRY_W-1:0]  rd_bits;
  logic                wr_en;
  logic [FAN_ID_W-1:0] wr_addr;
  fan_entry_t          wr_entry;
  logic [FAN_ID_W-1:0] out_id;
  fan_entry_t          out_entry;

  assign in_ch.ready = take;

  // Filter and decode.
  rffd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_ch.valid && take),
    .rf_code   (in_ch.rf_code),
    .protocol  (in_ch.protocol),
    .bit_count (in_ch.bit_count),
    .time_ms   (in_ch.time_ms),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .issue     (issue),
    .req       (req)
  );

  // Fan state table.
  rffd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FAN_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (issue && take),
    .raddr (req.id),
    .rdata (rd_bits)
  );

  assign rd_entry = fan_entry_t'(rd_bits);

  // Read-modify-write and result.
  rffd_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .req       (req),
    .take      (take),
    .rd_entry  (rd_entry),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_id    (out_id),
    .out_entry (out_entry)
  );

  assign out_ch.fan_id       = out_id;
  assign out_ch.fade_on      = out_entry.fade_on;
  assign out_ch.direction_up = out_entry.direction_up;
  assign out_ch.light_on     = out_entry.light_on;
  assign out_ch.fan_on       = out_entry.fan_on;
  assign out_ch.speed        = out_entry.speed;

endmodule

@@ bench/tb_rf_fan_remote_frame_decoder.sv @@
// Self-checking testbench for the fan remote frame decoder: directed table, then random frames.
`timescale 1ns / 1ps

module tb_rf_fan_remote_frame_decoder;
  import rffd_pkg::*;

  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_FRAMES = 290;

  // How the expectation of a request is obtained.
  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_NONE,
    EXP_GIVEN
  } exp_kind_e;

  typedef struct packed {
    logic [11:0] code;
    logic [4:0]  prot;
    logic [5:0]  nbits;
    logic [31:0] stamp;
  } frame_t;

  typedef struct packed {
    logic [3:0] fan_id;
    fan_entry_t entry;
  } fan_report_t;

  typedef struct packed {
    frame_t      frame;
    exp_kind_e   kind;
    fan_report_t given;
  } directed_frame_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  rffd_in_if  in_bus ();
  rffd_out_if out_bus ();

  rf_fan_remote_frame_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the fan table and repeat filter.
  fan_entry_t    fan_state [FAN_COUNT];
  logic [11:0]   last_code_q;
  logic [31:0]   last_time_q;
  logic [15:0]   window_q;
  fan_report_t   pending_reports [$];

  // Side information travelling with the request on the input bus.
  exp_kind_e     row_kind;
  fan_report_t   row_given;

  int            fail_count;
  bit            gaps_on;
  bit            stalls_on;
  int            stall_left;
  logic [15:0]   cur_window;
  logic [31:0]   sim_ms;
  logic [11:0]   prev_code;

  logic [5:0] cmd_list [9] = '{CMD_DIR_TOGGLE, CMD_LIGHT_TOGGLE, CMD_SPEED_1, CMD_SPEED_2,
                               CMD_SPEED_3, CMD_SPEED_4, CMD_SPEED_5, CMD_SPEED_6,
                               CMD_FAN_OFF};

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net against a hung run.
  initial begin
    #10_000_000;
    $display("rf_fan_remote_frame_decoder: mismatch");
    $finish;
  end

  // Builds a code word from fan index, fade flag and command.
  function automatic logic [11:0] frame_code(input logic [3:0] id, input logic fade,
                                             input logic [5:0] cmd);
    return {1'b0, ~id, ~fade, cmd};
  endfunction

  function automatic fan_report_t make_report(input logic [3:0] id, input logic fade,
                                              input logic dir, input logic light,
                                              input logic fan, input logic [2:0] spd);
    fan_report_t rep;
    rep.fan_id             = id;
    rep.entry.fade_on      = fade;
    rep.entry.direction_up = dir;
    rep.entry.light_on     = light;
    rep.entry.fan_on       = fan;
    rep.entry.speed        = spd;
    return rep;
  endfunction

  function automatic directed_frame_t make_row(input logic [11:0] code, input logic [4:0] prot,
                                               input logic [5:0] nbits, input logic [31:0] stamp,
                                               input exp_kind_e kind, input fan_report_t given);
    directed_frame_t row;
    row.frame.code  = code;
    row.frame.prot  = prot;
    row.frame.nbits = nbits;
    row.frame.stamp = stamp;
    row.kind        = kind;
    row.given       = given;
    return row;
  endfunction

  // Applies one frame to the mirrored state; returns 1 when the frame yields a report.
  function automatic bit apply_frame(input frame_t f, output fan_report_t rep);
    logic [3:0]  id;
    logic [31:0] age;
    rep = '0;
    if (f.prot < PROT_MIN || f.prot > PROT_MAX || f.nbits != FRAME_BITS || f.code[11]) begin
      return 1'b0;
    end
    age = f.stamp - last_time_q;
    if (f.code == last_code_q && age < {16'd0, window_q}) begin
      return 1'b0;
    end
    last_code_q = f.code;
    last_time_q = f.stamp;
    id = ~f.code[10:7];
    fan_state[id].fade_on = ~f.code[6];
    case (f.code[5:0])
      CMD_DIR_TOGGLE: begin
        fan_state[id].direction_up = ~fan_state[id].direction_up;
      end
      CMD_LIGHT_TOGGLE: begin
        fan_state[id].light_on = ~fan_state[id].light_on;
      end
      CMD_SPEED_1: begin
        fan_state[id].fan_on = 1'b1;
        fan_state[id].speed  = 3'd0;
      end
      CMD_SPEED_2: begin
        fan_state[id].fan_on = 1'b1;
        fan_state[id].speed  = 3'd1;
      end
      CMD_SPEED_3: begin
        fan_state[id].fan_on = 1'b1;
        fan_state[id].speed  = 3'd2;
      end
      CMD_SPEED_4: begin
        fan_state[id].fan_on = 1'b1;
        fan_state[id].speed  = 3'd3;
      end
      CMD_SPEED_5: begin
        fan_state[id].fan_on = 1'b1;
        fan_state[id].speed  = 3'd4;
      end
      CMD_SPEED_6: begin
        fan_state[id].fan_on = 1'b1;
        fan_state[id].speed  = 3'd5;
      end
      CMD_FAN_OFF: begin
        fan_state[id].fan_on = 1'b0;
      end
      default: begin
      end
    endcase
    rep.fan_id = id;
    rep.entry  = fan_state[id];
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Tracks accepted requests and configuration writes, and checks every report.
  always @(posedge clk) begin : monitor
    fan_report_t pred;
    fan_report_t want;
    frame_t      f;
    bit          hit;
    if (!rst_n) begin
      for (int i = 0; i < FAN_COUNT; i++) begin
        fan_state[i] = '0;
      end
      last_code_q = '0;
      last_time_q = '0;
      window_q    = WINDOW_RST;
    end else begin
      if (cfg_we) begin
        window_q = cfg_wdata;
      end
      if (in_bus.valid && in_bus.ready) begin
        f.code  = in_bus.rf_code;
        f.prot  = in_bus.protocol;
        f.nbits = in_bus.bit_count;
        f.stamp = in_bus.time_ms;
        hit = apply_frame(f, pred);
        case (row_kind)
          EXP_MODEL: begin
            if (hit) begin
              pending_reports.push_back(pred);
            end
          end
          EXP_GIVEN: begin
            pending_reports.push_back(row_given);
          end
          default: begin
          end
        endcase
      end
      if (out_bus.valid && out_bus.ready) begin
        if (pending_reports.size() == 0) begin
          $error("report for fan %0d with no request waiting", out_bus.fan_id);
          fail_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("fan_id", 32'(want.fan_id), 32'(out_bus.fan_id));
          check_field("fade_on", 32'(want.entry.fade_on), 32'(out_bus.fade_on));
          check_field("direction_up", 32'(want.entry.direction_up),
                      32'(out_bus.direction_up));
          check_field("light_on", 32'(want.entry.light_on), 32'(out_bus.light_on));
          check_field("fan_on", 32'(want.entry.fan_on), 32'(out_bus.fan_on));
          check_field("speed", 32'(want.entry.speed), 32'(out_bus.speed));
        end
      end
    end
  end

  // Result side back-pressure: short stalls mostly, a few long ones, and calm stretches.
  always @(negedge clk) begin : report_sink
    int r;
    if (stall_left > 0) begin
      out_bus.ready = 1'b0;
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (stalls_on && r < 25) begin
        out_bus.ready = 1'b0;
        stall_left    = $urandom_range(0, 2);
      end else if (stalls_on && r < 29) begin
        out_bus.ready = 1'b0;
        stall_left    = $urandom_range(9, 29);
      end else begin
        out_bus.ready = 1'b1;
      end
      if ($urandom_range(0, 199) == 0) begin
        stalls_on = !stalls_on;
      end
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  // Presents one request and holds it until taken, then idles for a random gap.
  task automatic send_frame(input frame_t f, input exp_kind_e kind, input fan_report_t given);
    int gap;
    @(negedge clk);
    in_bus.valid     = 1'b1;
    in_bus.rf_code   = f.code;
    in_bus.protocol  = f.prot;
    in_bus.bit_count = f.nbits;
    in_bus.time_ms   = f.stamp;
    row_kind         = kind;
    row_given        = given;
    do @(posedge clk); while (!in_bus.ready);
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid     = 1'b0;
      in_bus.rf_code   = 12'($urandom);
      in_bus.protocol  = 5'($urandom);
      in_bus.bit_count = 6'($urandom);
      in_bus.time_ms   = $urandom;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Holds the input idle until every pending report has arrived and the pipeline is empty.
  task automatic drain();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [15:0] value);
    @(negedge clk);
    cfg_we     = 1'b1;
    cfg_wdata  = value;
    cur_window = value;
    @(negedge clk);
    cfg_we     = 1'b0;
  endtask

  // One random request: mostly well-formed frames and repeats, some noise and broken frames.
  task automatic send_random_frame();
    frame_t f;
    int     r;
    r = $urandom_range(0, 99);
    f.code  = frame_code(4'($urandom), 1'($urandom),
                         ($urandom_range(0, 4) == 0) ? 6'($urandom)
                                                     : cmd_list[$urandom_range(0, 8)]);
    f.prot  = 5'($urandom_range(11, 13));
    f.nbits = FRAME_BITS;
    if (r < 3) begin
      sim_ms = $urandom;
    end else if (r < 5) begin
      sim_ms = 32'hffff_f000 + $urandom_range(0, 3000);
    end else begin
      sim_ms = sim_ms + $urandom_range(0, 1500);
    end
    f.stamp = sim_ms;
    if (r < 12) begin
      f.code  = 12'($urandom);
      f.prot  = 5'($urandom);
      f.nbits = 6'($urandom);
      f.stamp = $urandom;
    end else if (r < 18) begin
      case ($urandom_range(0, 2))
        0: f.prot = 5'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 10)
                                                    : $urandom_range(14, 31));
        1: f.nbits = 6'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 11)
                                                     : $urandom_range(13, 63));
        default: f.code[11] = 1'b1;
      endcase
    end else if (r < 40) begin
      f.code  = prev_code;
      f.stamp = sim_ms + $urandom_range(0, 32'(cur_window) + 32'(cur_window) / 4 + 2);
      sim_ms  = f.stamp;
    end else begin
      prev_code = f.code;
    end
    send_frame(f, EXP_MODEL, '0);
  endtask

  initial begin : stimulus
    directed_frame_t rows [$];
    fan_report_t     none;
    logic [15:0]     windows [5];
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_bus.valid     = 1'b0;
    in_bus.rf_code   = '0;
    in_bus.protocol  = '0;
    in_bus.bit_count = '0;
    in_bus.time_ms   = '0;
    out_bus.ready    = 1'b0;
    row_kind         = EXP_MODEL;
    row_given        = '0;
    fail_count       = 0;
    gaps_on          = 1'b1;
    stalls_on        = 1'b1;
    stall_left       = 0;
    cur_window       = WINDOW_RST;
    sim_ms           = 32'd5000;
    prev_code        = '0;
    none             = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Code zero right after reset matches the cleared last code until the window expires.
    rows.push_back(make_row(12'h000, 5'd12, 6'd12, 32'd0, EXP_NONE, none));
    rows.push_back(make_row(12'h000, 5'd12, 6'd12, 32'd499, EXP_NONE, none));
    rows.push_back(make_row(12'h000, 5'd12, 6'd12, 32'd500, EXP_GIVEN,
                            make_report(4'd15, 1'b1, 1'b0, 1'b0, 1'b0, 3'd0)));
    rows.push_back(make_row(frame_code(4'd0, 1'b1, CMD_SPEED_6), 5'd11, 6'd12, 32'd1000,
                            EXP_GIVEN, make_report(4'd0, 1'b1, 1'b0, 1'b0, 1'b1, 3'd5)));
    rows.push_back(make_row(frame_code(4'd0, 1'b0, CMD_SPEED_1), 5'd13, 6'd12, 32'd1001,
                            EXP_GIVEN, make_report(4'd0, 1'b0, 1'b0, 1'b0, 1'b1, 3'd0)));
    // Repeat inside the window, then just at its edge.
    rows.push_back(make_row(frame_code(4'd0, 1'b0, CMD_SPEED_1), 5'd12, 6'd12, 32'd1500,
                            EXP_NONE, none));
    rows.push_back(make_row(frame_code(4'd0, 1'b0, CMD_SPEED_1), 5'd12, 6'd12, 32'd1501,
                            EXP_GIVEN, make_report(4'd0, 1'b0, 1'b0, 1'b0, 1'b1, 3'd0)));
    // Rejected frames: protocol, bit count and top bit.
    rows.push_back(make_row(frame_code(4'd1, 1'b1, CMD_SPEED_2), 5'd10, 6'd12, 32'd2000,
                            EXP_NONE, none));
    rows.push_back(make_row(frame_code(4'd1, 1'b1, CMD_SPEED_2), 5'd14, 6'd12, 32'd2000,
                            EXP_NONE, none));
    rows.push_back(make_row(frame_code(4'd1, 1'b1, CMD_SPEED_2), 5'd0, 6'd12, 32'd2000,
                            EXP_NONE, none));
    rows.push_back(make_row(frame_code(4'd1, 1'b1, CMD_SPEED_2), 5'd31, 6'd12, 32'd2000,
                            EXP_NONE, none));
    rows.push_back(make_row(frame_code(4'd1, 1'b1, CMD_SPEED_2), 5'd12, 6'd11, 32'd2000,
                            EXP_NONE, none));
    rows.push_back(make_row(frame_code(4'd1, 1'b1, CMD_SPEED_2), 5'd12, 6'd13, 32'd2000,
                            EXP_NONE, none));
    rows.push_back(make_row(frame_code(4'd1, 1'b1, CMD_SPEED_2), 5'd12, 6'd0, 32'd2000,
                            EXP_NONE, none));
    rows.push_back(make_row(frame_code(4'd1, 1'b1, CMD_SPEED_2), 5'd12, 6'd63, 32'd2000,
                            EXP_NONE, none));
    rows.push_back(make_row(12'hfff, 5'd12, 6'd12, 32'hffff_ffff, EXP_NONE, none));
    rows.push_back(make_row(12'h800, 5'd12, 6'd12, 32'd2000, EXP_NONE, none));
    // Every command but CMD_SPEED_1 and CMD_SPEED_6 on one fan.
    rows.push_back(make_row(frame_code(4'd1, 1'b1, CMD_DIR_TOGGLE), 5'd12, 6'd12, 32'd3000,
                            EXP_GIVEN, make_report(4'd1, 1'b1, 1'b1, 1'b0, 1'b0, 3'd0)));
    rows.push_back(make_row(frame_code(4'd1, 1'b1, CMD_LIGHT_TOGGLE), 5'd12, 6'd12, 32'd3001,
                            EXP_GIVEN, make_report(4'd1, 1'b1, 1'b1, 1'b1, 1'b0, 3'd0)));
    rows.push_back(make_row(frame_code(4'd1, 1'b0, CMD_SPEED_2), 5'd11, 6'd12, 32'd3002,
                            EXP_MODEL, none));
    rows.push_back(make_row(frame_code(4'd1, 1'b1, CMD_SPEED_3), 5'd12, 6'd12, 32'd3003,
                            EXP_MODEL, none));
    rows.push_back(make_row(frame_code(4'd1, 1'b0, CMD_SPEED_4), 5'd13, 6'd12, 32'd3004,
                            EXP_MODEL, none));
    rows.push_back(make_row(frame_code(4'd1, 1'b1, CMD_SPEED_5), 5'd12, 6'd12, 32'd3005,
                            EXP_MODEL, none));
    rows.push_back(make_row(frame_code(4'd1, 1'b1, CMD_FAN_OFF), 5'd12, 6'd12, 32'd3006,
                            EXP_MODEL, none));
    // An unknown command only refreshes the fade flag.
    rows.push_back(make_row(frame_code(4'd2, 1'b1, 6'h2a), 5'd12, 6'd12, 32'd3007,
                            EXP_MODEL, none));
    // Repeat detection across the wrap of the millisecond counter.
    rows.push_back(make_row(frame_code(4'd3, 1'b1, CMD_DIR_TOGGLE), 5'd12, 6'd12,
                            32'hffff_ff00, EXP_MODEL, none));
    rows.push_back(make_row(frame_code(4'd3, 1'b1, CMD_DIR_TOGGLE), 5'd12, 6'd12,
                            32'h0000_00f0, EXP_NONE, none));
    foreach (rows[i]) begin
      send_frame(rows[i].frame, rows[i].kind, rows[i].given);
    end

    // Random phases, the first with the reset window and the rest after a register write.
    windows[0] = 16'd0;
    windows[1] = 16'hffff;
    windows[2] = 16'($urandom_range(1, 2000));
    windows[3] = 16'd1;
    windows[4] = 16'($urandom_range(2001, 65534));
    for (int p = 0; p <= 5; p++) begin
      drain();
      if (p > 0) begin
        write_window(windows[p - 1]);
      end
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        if (n % 50 == 0) begin
          gaps_on = ($urandom_range(0, 9) < 7);
        end
        send_random_frame();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("rf_fan_remote_frame_decoder: match");
    end else begin
      $display("rf_fan_remote_frame_decoder: mismatch");
    end
    $finish;
  end

endmodule
